// File: rtl/core/svlf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package svlf_pkg;

  // Fixed field widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned GainW    = 16;
  localparam int unsigned FrameW   = 32;
  localparam int unsigned RatioW   = 16;
  localparam int unsigned McandW   = 32;
  localparam int unsigned ProdW    = McandW + RatioW;
  // Fractional bits in the product: Q4.12 volume times Q0.16 ratio
  localparam int unsigned ProdFrac = 28;
  localparam int unsigned MagW     = ProdW - ProdFrac;

  // One bit per cycle in the serial units
  localparam int unsigned StepCnt  = 16;
  localparam int unsigned StepCntW = 4;
  localparam logic [StepCntW-1:0] LastStep = StepCntW'(StepCnt - 1);

  // Register map
  localparam int unsigned AddrW = 4;
  localparam logic [1:0] RegVolume    = 2'd0;
  localparam logic [1:0] RegFadeStart = 2'd1;
  localparam logic [1:0] RegTotal     = 2'd2;

  localparam logic [GainW-1:0] VolumeReset = 16'd4096;

  // Saturation limits
  localparam logic [MagW-1:0] PosLimit = 20'd32767;
  localparam logic [MagW-1:0] NegLimit = 20'd32768;
  localparam logic signed [SampleW-1:0] SatMax = 16'sh7fff;
  localparam logic signed [SampleW-1:0] SatMin = 16'sh8000;

  typedef struct packed {
    logic signed [SampleW-1:0] left_in;
    logic signed [SampleW-1:0] right_in;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] left_out;
    logic signed [SampleW-1:0] right_out;
    logic                      track_done;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_GAIN,
    ST_MSTART,
    ST_MUL,
    ST_WB
  } state_e;

endpackage

`default_nettype wire

// File: rtl/core/svlf_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle; dividend must be below divisor
module svlf_div import svlf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [FrameW-1:0] dividend_i,
  input  wire logic [FrameW-1:0] divisor_i,
  output logic                   done_o,
  output logic [RatioW-1:0]      quot_o
);

  logic                busy_q;
  logic                done_q;
  logic [StepCntW-1:0] cnt_q;
  logic [FrameW-1:0]   rem_q;
  logic [FrameW-1:0]   div_q;
  logic [RatioW-1:0]   quot_q;

  logic [FrameW:0] trial;
  logic [FrameW:0] diff;
  logic            fits;

  // Shift the partial remainder and trial-subtract
  always_comb begin
    trial = {rem_q, 1'b0};
    diff  = trial - {1'b0, div_q};
    fits  = ~diff[FrameW];
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + StepCntW'(1);
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      div_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= fits ? diff[FrameW-1:0] : trial[FrameW-1:0];
      quot_q <= {quot_q[RatioW-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

// File: rtl/core/svlf_mul.sv
`timescale 1ns / 1ps
`default_nettype none

// Shift-add multiplier, one multiplier bit per cycle, LSB first
module svlf_mul import svlf_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [McandW-1:0] mcand_i,
  input  wire logic [RatioW-1:0] mplier_i,
  output logic                   done_o,
  output logic [ProdW-1:0]       prod_o
);

  logic                busy_q;
  logic                done_q;
  logic [StepCntW-1:0] cnt_q;
  logic [McandW-1:0]   mcand_q;
  logic [McandW-1:0]   hi_q;
  logic [RatioW-1:0]   lo_q;

  logic [McandW:0] sum;

  // Partial product add; the sum shifts right into the low half
  always_comb begin
    sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, mcand_q} : '0);
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LastStep);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + StepCntW'(1);
        if (cnt_q == LastStep) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mcand_q <= mcand_i;
      hi_q    <= '0;
      lo_q    <= mplier_i;
    end else if (busy_q) begin
      hi_q <= sum[McandW:1];
      lo_q <= {sum[0], lo_q[RatioW-1:1]};
    end
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

`default_nettype wire

// File: rtl/core/stereo_volume_linear_fadeout.sv
// Sequence: PREP; if fading, serial divider and gain multiplier (DIV, GAIN);
// then both sample multipliers (MSTART, MUL); WB registers the result. Once the
// track is done PREP goes straight to WB. A new frame is taken only back in IDLE,
// after the result is registered. One frame is processed at a time.
// Reset: asynchronous, active low; frame position 0, volume 4096, fade start
// and total 0, output register empty.
`timescale 1ns / 1ps
`default_nettype none

module stereo_volume_linear_fadeout import svlf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // input frames
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire in_t              in_data_i,
  // output frames
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output out_t                  out_data_o,
  // APB configuration
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [31:0]      pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  state_e state_q, state_d;

  logic [GainW-1:0]   vol_q;
  logic [FrameW-1:0]  fade_q;
  logic [FrameW-1:0]  total_q;
  logic [FrameW-1:0]  pos_q;
  logic               fin_q;
  logic               negl_q, negr_q;
  logic [SampleW-1:0] magl_q, magr_q;
  logic [McandW-1:0]  g_q, g_d;
  logic               g_load;
  logic               out_valid_q;
  out_t               out_q;

  logic        in_acc, cfg_wr, fin, fading, pos_inc, out_load;
  logic        div_start, gmul_start, smul_start;
  logic        div_done, gmul_done, lmul_done, rmul_done;
  logic [RatioW-1:0] ratio;
  logic [ProdW-1:0]  gprod, lprod, rprod;
  out_t        res;

  // Saturate a magnitude with its sign back to 16 bits
  function automatic logic signed [SampleW-1:0] sat16(input logic neg,
                                                      input logic [MagW-1:0] m);
    logic signed [SampleW-1:0] r;
    if (neg) begin
      r = (m > NegLimit) ? SatMin : $signed(~m[SampleW-1:0] + SampleW'(1));
    end else begin
      r = (m > PosLimit) ? SatMax : $signed(m[SampleW-1:0]);
    end
    return r;
  endfunction

  // APB register file
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vol_q   <= VolumeReset;
      fade_q  <= '0;
      total_q <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        RegVolume:    vol_q   <= pwdata[GainW-1:0];
        RegFadeStart: fade_q  <= pwdata;
        RegTotal:     total_q <= pwdata;
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegVolume:    prdata = {16'h0, vol_q};
      RegFadeStart: prdata = fade_q;
      RegTotal:     prdata = total_q;
      default:      prdata = '0;
    endcase
  end

  // Frame decisions
  assign in_acc = in_valid_i && !in_stall_o;
  assign fin    = pos_q >= total_q;
  assign fading = (total_q > fade_q) && (pos_q > fade_q);

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    gmul_start = 1'b0;
    smul_start = 1'b0;
    g_load     = 1'b0;
    g_d        = {vol_q, 16'h0};
    pos_inc    = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        pos_inc = !fin;
        priority if (fin) begin
          state_d = ST_WB;
        end else if (fading) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end else begin
          g_load  = 1'b1;
          state_d = ST_MSTART;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          gmul_start = 1'b1;
          state_d    = ST_GAIN;
        end
      end
      ST_GAIN: begin
        if (gmul_done) begin
          g_load  = 1'b1;
          g_d     = gprod[McandW-1:0];
          state_d = ST_MSTART;
        end
      end
      ST_MSTART: begin
        smul_start = 1'b1;
        state_d    = ST_MUL;
      end
      ST_MUL: begin
        if (lmul_done && rmul_done) begin
          state_d = ST_WB;
        end
      end
      ST_WB: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Position counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (pos_inc) begin
      pos_q <= pos_q + FrameW'(1);
    end
  end

  // Sample magnitudes, done flag and gain
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      negl_q <= in_data_i.left_in[SampleW-1];
      negr_q <= in_data_i.right_in[SampleW-1];
      magl_q <= in_data_i.left_in[SampleW-1] ?
                (~in_data_i.left_in + SampleW'(1)) : in_data_i.left_in;
      magr_q <= in_data_i.right_in[SampleW-1] ?
                (~in_data_i.right_in + SampleW'(1)) : in_data_i.right_in;
    end
    if (state_q == ST_PREP) begin
      fin_q <= fin;
    end
    if (g_load) begin
      g_q <= g_d;
    end
  end

  // Ratio (total - pos) / (total - fade start) in Q0.16
  svlf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (total_q - pos_q),
    .divisor_i  (total_q - fade_q),
    .done_o     (div_done),
    .quot_o     (ratio)
  );

  // Combined gain volume * ratio
  svlf_mul u_gmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (gmul_start),
    .mcand_i  ({16'h0, vol_q}),
    .mplier_i (ratio),
    .done_o   (gmul_done),
    .prod_o   (gprod)
  );

  // Per-channel sample scaling
  svlf_mul u_lmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (smul_start),
    .mcand_i  (g_q),
    .mplier_i (magl_q),
    .done_o   (lmul_done),
    .prod_o   (lprod)
  );

  svlf_mul u_rmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (smul_start),
    .mcand_i  (g_q),
    .mplier_i (magr_q),
    .done_o   (rmul_done),
    .prod_o   (rprod)
  );

  // Result: silent and flagged once the track is done
  always_comb begin
    if (fin_q) begin
      res.left_out   = '0;
      res.right_out  = '0;
      res.track_done = 1'b1;
    end else begin
      res.left_out   = sat16(negl_q, lprod[ProdW-1:ProdFrac]);
      res.right_out  = sat16(negr_q, rprod[ProdW-1:ProdFrac]);
      res.track_done = 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: sim/stereo_volume_linear_fadeout_test.sv
`timescale 1ns / 1ps

module stereo_volume_linear_fadeout_test;
  import svlf_pkg::*;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned SettleCycles = 60;
  localparam int unsigned RandomFrames = 500;

  // Predicts the faded frames and holds them until the block returns them
  class fade_scoreboard;
    logic [15:0] gain;
    logic [31:0] fade_start;
    logic [31:0] total;
    logic [31:0] position;
    out_t        frames_due[$];
    int unsigned errors;

    function void clear();
      gain = VolumeReset;
      fade_start = '0;
      total = '0;
      position = '0;
      frames_due.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        RegVolume:    gain = value[15:0];
        RegFadeStart: fade_start = value;
        RegTotal:     total = value;
        default: ;
      endcase
    endfunction

    function int unsigned pending();
      return frames_due.size();
    endfunction

    // Magnitude scaling, truncation toward zero, then saturation
    function logic signed [15:0] scale(logic signed [15:0] s, logic [15:0] ratio, bit fading);
      int signed   wide;
      logic [63:0] mag;
      wide = s;
      mag = (wide < 0) ? 64'(-wide) : 64'(wide);
      mag = mag * {48'b0, gain};
      if (fading) begin
        mag = (mag * {48'b0, ratio}) >> 28;
      end else begin
        mag = mag >> 12;
      end
      if (wide < 0) begin
        if (mag > 64'd32768) mag = 64'd32768;
        return 16'(64'd0 - mag);
      end
      if (mag > 64'd32767) mag = 64'd32767;
      return 16'(mag);
    endfunction

    function void note_frame(in_t f);
      out_t        want;
      logic [63:0] len;
      logic [63:0] rem;
      logic [63:0] ratio;
      bit          fading;
      fading = 1'b0;
      ratio = '0;
      if (position >= total) begin
        // track over: silence, position held
        want.left_out = '0;
        want.right_out = '0;
        want.track_done = 1'b1;
      end else begin
        if (total > fade_start && position > fade_start) begin
          len = {32'b0, total} - {32'b0, fade_start};
          rem = {32'b0, total} - {32'b0, position};
          ratio = (rem << 16) / len;
          if (ratio > 64'hFFFF) ratio = 64'hFFFF;
          fading = 1'b1;
        end
        want.left_out = scale(f.left_in, ratio[15:0], fading);
        want.right_out = scale(f.right_in, ratio[15:0], fading);
        want.track_done = 1'b0;
        position = position + 32'd1;
      end
      frames_due.push_back(want);
    endfunction

    function void check_frame(out_t got);
      out_t want;
      if (frames_due.size() == 0) begin
        $display("%0t: unexpected frame, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = frames_due.pop_front();
      if (got.left_out !== want.left_out) begin
        $display("%0t: left_out mismatch, expected %0d, actual %0d",
                 $time, want.left_out, got.left_out);
        errors++;
      end
      if (got.right_out !== want.right_out) begin
        $display("%0t: right_out mismatch, expected %0d, actual %0d",
                 $time, want.right_out, got.right_out);
        errors++;
      end
      if (got.track_done !== want.track_done) begin
        $display("%0t: track_done mismatch, expected %0b, actual %0b",
                 $time, want.track_done, got.track_done);
        errors++;
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_n = 1'b0;
  logic             frame_valid = 1'b0;
  in_t              frame_data = '0;
  logic             result_stall = 1'b0;
  logic             psel_r = 1'b0;
  logic             penable_r = 1'b0;
  logic             pwrite_r = 1'b0;
  logic [AddrW-1:0] paddr_r = '0;
  logic [31:0]      pwdata_r = '0;
  logic             in_stall_o;
  logic             out_valid_o;
  out_t             out_data_o;
  logic [31:0]      prdata;
  logic             pready;

  fade_scoreboard   board;
  int unsigned      cycles = 0;
  int unsigned      burst_left = 0;
  int unsigned      stall_left = 0;
  int unsigned      stall_mode = 0;

  stereo_volume_linear_fadeout dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (frame_valid),
    .in_stall_o  (in_stall_o),
    .in_data_i   (frame_data),
    .out_valid_o (out_valid_o),
    .out_stall_i (result_stall),
    .out_data_o  (out_data_o),
    .psel        (psel_r),
    .penable     (penable_r),
    .pwrite      (pwrite_r),
    .paddr       (paddr_r),
    .pwdata      (pwdata_r),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // Receiver stall: one of four random stall patterns, switched at random
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: result_stall <= 1'b0;
      1: result_stall <= 1'($urandom_range(0, 1));
      2: result_stall <= ($urandom_range(0, 7) == 0);
      default: result_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Output transaction monitor
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && !result_stall) board.check_frame(out_data_o);
  end

  // Register write followed by a read back of the same register
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] want;
    want = (idx == RegVolume) ? {16'b0, value[15:0]} : value;
    psel_r <= 1'b1;
    penable_r <= 1'b0;
    pwrite_r <= 1'b1;
    paddr_r <= {idx, 2'b00};
    pwdata_r <= value;
    @(posedge clk_i);
    penable_r <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    board.set_reg(idx, value);
    pwrite_r <= 1'b0;
    penable_r <= 1'b0;
    @(posedge clk_i);
    penable_r <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== want) begin
      $display("%0t: register %0d read back mismatch, expected %h, actual %h",
               $time, idx, want, prdata);
      board.errors++;
    end
    psel_r <= 1'b0;
    penable_r <= 1'b0;
    @(posedge clk_i);
  endtask

  // Hold the sender until every predicted frame has come back
  task automatic drain();
    frame_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic configure(input logic [31:0] gain, input logic [31:0] fade,
                           input logic [31:0] total);
    drain();
    write_reg(RegVolume, gain);
    write_reg(RegFadeStart, fade);
    write_reg(RegTotal, total);
  endtask

  // One input transaction, with bursts and random gaps between them
  task automatic send_frame(input logic [15:0] left, input logic [15:0] right);
    int unsigned gap;
    in_t         f;
    f.left_in = left;
    f.right_in = right;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap != 0) begin
        frame_valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    frame_valid <= 1'b1;
    frame_data <= f;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_frame(f);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 11))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4: return 16'h0001;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned count;
    logic [31:0] pos;
    logic [31:0] fade;
    logic [31:0] total;
    logic [31:0] gain;
    board = new();
    board.clear();
    repeat (7) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Out of reset the total is zero, so the track is already over
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h1234, 16'hFFFF);

    // Fade start equal to total: volume only, unity gain
    configure(32'd4096, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h0000, 16'hFFFF);
    send_frame(16'h0001, 16'hFFFE);

    // Full scale gain saturates; small values truncate toward zero
    configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h0001, 16'hFFFF);

    // Zero gain silences without ending the track
    configure(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_frame(16'h7FFF, 16'h8000);

    // Short fade of four frames running into the end of the track
    pos = board.position;
    configure(32'd4096, pos, pos + 32'd4);
    repeat (6) send_frame(16'h7FFF, 16'h8000);

    // Raising the total resumes output; very long fade from frame zero
    configure(32'h0000_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h4000, 16'hC000);

    // Fade of length one: the last frame before the end is not faded
    pos = board.position;
    configure(32'd4096, pos, pos + 32'd1);
    send_frame(16'h7FFF, 16'h8000);
    send_frame(16'h7FFF, 16'h8000);

    // Fade start beyond total while counting up to it
    pos = board.position;
    configure(32'd8192, pos + 32'd5, pos + 32'd3);
    repeat (4) send_frame(16'h3FFF, 16'hC001);

    // Random settings, each held for a run of frames
    sent = 0;
    while (sent < RandomFrames) begin
      pos = board.position;
      case ($urandom_range(0, 5))
        0: begin
          fade = pos + $urandom_range(0, 10);
          total = fade + $urandom_range(1, 60);
        end
        1: begin
          fade = pos - ((pos < 40) ? $urandom_range(0, pos) : $urandom_range(0, 40));
          total = pos + $urandom_range(1, 60);
        end
        2: begin
          fade = $urandom;
          total = $urandom;
        end
        3: begin
          fade = 32'd0;
          total = 32'hFFFF_FFFF;
        end
        4: begin
          total = pos + $urandom_range(0, 20);
          fade = total + $urandom_range(0, 5);
        end
        default: begin
          fade = 32'hFFFF_FFFF - $urandom_range(0, 3);
          total = 32'hFFFF_FFFF;
        end
      endcase
      case ($urandom_range(0, 4))
        0: gain = 32'd0;
        1: gain = 32'd4096;
        2: gain = 32'h0000_FFFF;
        default: gain = $urandom;
      endcase
      configure(gain, fade, total);
      count = $urandom_range(10, 50);
      repeat (count) begin
        send_frame(pick_sample(), pick_sample());
        sent++;
        // occasional pause until the block has caught up
        if ($urandom_range(0, 99) == 0) begin
          frame_valid <= 1'b0;
          while (board.pending() != 0) @(posedge clk_i);
        end
      end
    end

    drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/svlf_pkg.sv
rtl/core/svlf_div.sv
rtl/core/svlf_mul.sv
rtl/core/stereo_volume_linear_fadeout.sv
sim/stereo_volume_linear_fadeout_test.sv
